// ----- rtl/ffba_pkg.sv -----
// Shared types, widths and codes of the first-fit block allocator.
package ffba_pkg;

  localparam int REQ_W   = 13;
  localparam int ADDR_W  = 12;
  localparam int FREE_W  = 13;
  localparam int MODE_W  = 2;
  localparam int CFG_W   = 13;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 3;

  localparam logic [CFG_W-1:0] POOL_SIZE_RST = 13'd4096;

  // Operation codes carried on the input tuser
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE  = 2'd3;

  // Register word index of pool_size
  localparam logic [PADDR_W-3:0] REG_POOL_SIZE = 1'b0;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic init;      // latch pool size, write the single free block
    logic load;      // capture the input item, restart the walk
    logic rd;        // read the header at the walk pointer
    logic step;      // advance the walk pointer past the current block
    logic take;      // mark the current block used
    logic split_wr;  // write the header of the split-off remainder
    logic rel;       // clear the used mark of the current block
    logic merge;     // one coalescing step on the current block
    logic walk_rst;  // restart the walk at offset zero
    logic ok;        // mark the result a success
  } ffba_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              req_ok;  // request fits within the free byte count
    logic              blk_ok;  // a valid block starts at the walk pointer
    logic              fits;    // current block is free and large enough
    logic              split;   // remainder can hold a header
    logic              hit;     // current payload offset matches the address
    logic              used;    // current block is in use
  } ffba_sts_t;

endpackage

// ----- rtl/first_fit_block_allocator_core.sv -----
// First-fit block allocator with coalescing: top level with stream and register ports.
//
// The pool is a chain of blocks, each a header followed by its payload, kept in a
// header memory with one entry per byte offset. Mode 0 allocates the first free
// block that holds request_size bytes (splitting off the rest when it can carry a
// header), mode 1 frees the block whose payload starts at block_address and then
// merges adjacent free blocks, mode 2 rebuilds the pool as one free block of
// pool_size bytes (clamped to HEADER_BYTES..POOL_BYTES; a new pool_size takes
// effect only at that point), mode 3 does nothing and reports a failure. Every
// item yields exactly one result. The header memory has a single registered read
// port, so each block visited by a walk is read in one state and examined in the
// next. An allocate walks the blocks up to the first that fits, with a further
// state for a split; a request above the free byte count fails without a walk. A
// free walks until it finds its block or the end of the chain, then walks over all
// blocks to merge them and hands off the result; a pool reset goes straight to the
// hand-off. After reset the initial block is written in a state during which no
// item is taken. A finished result sits in the output register while the next
// item is accepted and worked on.
module first_fit_block_allocator_core #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // [12:0] request_size, [24:13] block_address, [31:25] zero
  input  logic [ffba_pkg::DATA_W-1:0]  s_axis_tdata,
  // [1:0] mode
  input  logic [ffba_pkg::MODE_W-1:0]  s_axis_tuser,
  // Result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [11:0] payload_address, [24:12] free_space, [31:25] zero
  output logic [ffba_pkg::DATA_W-1:0]  m_axis_tdata,
  // [0] status
  output logic                         m_axis_tuser,
  // Register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffba_pkg::PADDR_W-1:0] paddr,
  input  logic [ffba_pkg::DATA_W-1:0]  pwdata,
  output logic [ffba_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import ffba_pkg::*;

  ffba_cmd_t cmd;
  ffba_sts_t sts;

  logic [CFG_W-1:0]  pool_size_q;
  logic              reg_hit, reg_wr;
  logic              finish, out_free;
  logic              fail;
  logic [ADDR_W-1:0] payload;
  logic [FREE_W-1:0] free_bytes;

  logic              out_valid_q;
  logic              out_status_q;
  logic [ADDR_W-1:0] out_payload_q;
  logic [FREE_W-1:0] out_free_q;

  // Register port: single register, no wait states
  assign pready  = 1'b1;
  assign reg_hit = paddr[PADDR_W-1:2] == REG_POOL_SIZE;
  assign reg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? DATA_W'(pool_size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q <= POOL_SIZE_RST;
    end else if (reg_wr) begin
      pool_size_q <= pwdata[CFG_W-1:0];
    end
  end

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_free_i (out_free),
    .finish_o   (finish),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ffba_dp #(
    .POOL_BYTES   (POOL_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .pool_size_i (pool_size_q),
    .mode_i      (s_axis_tuser),
    .req_i       (s_axis_tdata[REQ_W-1:0]),
    .addr_i      (s_axis_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .fail_o      (fail),
    .payload_o   (payload),
    .free_o      (free_bytes)
  );

  // Output register: the slot is free when empty or drained this cycle
  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the result fields until the transfer completes
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q  <= fail;
      out_payload_q <= payload;
      out_free_q    <= free_bytes;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = DATA_W'({out_free_q, out_payload_q});

endmodule

// ----- rtl/ffba_dp.sv -----
// Datapath of the allocator: header memory, walk pointer and byte counters.
module ffba_dp #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ffba_pkg::ffba_cmd_t         cmd_i,
  output ffba_pkg::ffba_sts_t         sts_o,
  input  logic [ffba_pkg::CFG_W-1:0]  pool_size_i,
  input  logic [ffba_pkg::MODE_W-1:0] mode_i,
  input  logic [ffba_pkg::REQ_W-1:0]  req_i,
  input  logic [ffba_pkg::ADDR_W-1:0] addr_i,
  output logic                        fail_o,
  output logic [ffba_pkg::ADDR_W-1:0] payload_o,
  output logic [ffba_pkg::FREE_W-1:0] free_o
);
  import ffba_pkg::*;

  localparam int SW = $clog2(POOL_BYTES + 1);
  localparam int AW = $clog2(POOL_BYTES);
  localparam int WW = (SW + 1 > REQ_W) ? SW + 1 : REQ_W;
  localparam logic [WW-1:0] HDR_W  = WW'(HEADER_BYTES);
  localparam logic [WW-1:0] POOL_W = WW'(POOL_BYTES);

  typedef struct packed {
    logic          used;
    logic [SW-1:0] size;
  } hdr_t;

  hdr_t hdr_mem [POOL_BYTES];
  hdr_t rd_q;

  logic [SW-1:0]     at_q, at_d;
  logic [SW-1:0]     prev_q, prev_d;
  logic [SW-1:0]     prev_size_q, prev_size_d;
  logic              have_prev_q, have_prev_d;
  logic [SW-1:0]     free_q, free_d;
  logic [SW-1:0]     active_q, active_d;
  logic              fail_q, fail_d;
  logic [ADDR_W-1:0] payload_q, payload_d;
  logic [MODE_W-1:0] mode_q;
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;

  logic [WW-1:0] at_w, size_w, act_w, req_w, free_w, cfg_w;
  logic [WW-1:0] hdr_end, rem_w, step_w, clamp_w;
  logic          blk_ok, fits, split, join_prev;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  hdr_t          wr_data;

  assign at_w    = WW'(at_q);
  assign size_w  = WW'(rd_q.size);
  assign act_w   = WW'(active_q);
  assign req_w   = WW'(req_q);
  assign free_w  = WW'(free_q);
  assign cfg_w   = WW'(pool_size_i);
  assign hdr_end = at_w + HDR_W;
  assign rem_w   = size_w - req_w;
  assign step_w  = size_w + HDR_W;
  assign clamp_w = (cfg_w > POOL_W) ? POOL_W : ((cfg_w < HDR_W) ? HDR_W : cfg_w);

  assign blk_ok    = (hdr_end <= act_w) && (size_w <= act_w - hdr_end);
  assign fits      = !rd_q.used && (size_w >= req_w);
  assign split     = rem_w >= HDR_W;
  assign join_prev = !rd_q.used && have_prev_q;

  always_comb begin
    sts_o.mode   = mode_q;
    sts_o.req_ok = req_w <= free_w;
    sts_o.blk_ok = blk_ok;
    sts_o.fits   = fits;
    sts_o.split  = split;
    sts_o.hit    = hdr_end == WW'(addr_q);
    sts_o.used   = rd_q.used;
  end

  // Header write port: one write per cycle at most
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.init) begin
      wr_en        = 1'b1;
      wr_data.size = SW'(clamp_w - HDR_W);
    end else if (cmd_i.take) begin
      wr_en        = 1'b1;
      wr_addr      = at_q[AW-1:0];
      wr_data.used = 1'b1;
      wr_data.size = split ? SW'(req_w) : rd_q.size;
    end else if (cmd_i.split_wr) begin
      wr_en        = 1'b1;
      wr_addr      = AW'(hdr_end + req_w);
      wr_data.size = SW'(rem_w - HDR_W);
    end else if (cmd_i.rel) begin
      wr_en        = 1'b1;
      wr_addr      = at_q[AW-1:0];
      wr_data.size = rd_q.size;
    end else if (cmd_i.merge && join_prev) begin
      wr_en        = 1'b1;
      wr_addr      = prev_q[AW-1:0];
      wr_data.size = SW'(WW'(prev_size_q) + step_w);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      hdr_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rd_q <= hdr_mem[at_q[AW-1:0]];
    end
    if (cmd_i.load) begin
      mode_q <= mode_i;
      req_q  <= req_i;
      addr_q <= addr_i;
    end
  end

  always_comb begin
    at_d        = at_q;
    prev_d      = prev_q;
    prev_size_d = prev_size_q;
    have_prev_d = have_prev_q;
    free_d      = free_q;
    active_d    = active_q;
    fail_d      = fail_q;
    payload_d   = payload_q;
    if (cmd_i.load) begin
      at_d      = '0;
      fail_d    = 1'b1;
      payload_d = '0;
    end
    if (cmd_i.walk_rst) begin
      at_d        = '0;
      have_prev_d = 1'b0;
    end
    if (cmd_i.step) begin
      at_d = SW'(at_w + step_w);
    end
    if (cmd_i.init) begin
      active_d = SW'(clamp_w);
      free_d   = SW'(clamp_w - HDR_W);
    end
    if (cmd_i.take) begin
      free_d    = split ? SW'(free_w - req_w - HDR_W) : SW'(free_w - size_w);
      payload_d = ADDR_W'(hdr_end);
    end
    if (cmd_i.rel) begin
      free_d = SW'(free_w + size_w);
    end
    if (cmd_i.merge) begin
      at_d = SW'(at_w + step_w);
      if (rd_q.used) begin
        have_prev_d = 1'b0;
      end else if (have_prev_q) begin
        prev_size_d = SW'(WW'(prev_size_q) + step_w);
        free_d      = SW'(free_w + HDR_W);
      end else begin
        prev_d      = at_q;
        prev_size_d = rd_q.size;
        have_prev_d = 1'b1;
      end
    end
    if (cmd_i.ok) begin
      fail_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_q        <= '0;
      prev_q      <= '0;
      prev_size_q <= '0;
      have_prev_q <= 1'b0;
      free_q      <= '0;
      active_q    <= '0;
      fail_q      <= 1'b1;
      payload_q   <= '0;
    end else begin
      at_q        <= at_d;
      prev_q      <= prev_d;
      prev_size_q <= prev_size_d;
      have_prev_q <= have_prev_d;
      free_q      <= free_d;
      active_q    <= active_d;
      fail_q      <= fail_d;
      payload_q   <= payload_d;
    end
  end

  assign fail_o    = fail_q;
  assign payload_o = payload_q;
  assign free_o    = FREE_W'(free_q);

endmodule

// ----- rtl/ffba_ctrl.sv -----
// Controller of the allocator: sequences the header walks of each operation.
module ffba_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_free_i,
  output logic                finish_o,
  input  ffba_pkg::ffba_sts_t sts_i,
  output ffba_pkg::ffba_cmd_t cmd_o
);
  import ffba_pkg::*;

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_DISP  = 4'd2;
  localparam logic [3:0] ST_A_RD  = 4'd3;
  localparam logic [3:0] ST_A_EX  = 4'd4;
  localparam logic [3:0] ST_A_SPL = 4'd5;
  localparam logic [3:0] ST_F_RD  = 4'd6;
  localparam logic [3:0] ST_F_EX  = 4'd7;
  localparam logic [3:0] ST_M_ST  = 4'd8;
  localparam logic [3:0] ST_M_RD  = 4'd9;
  localparam logic [3:0] ST_M_EX  = 4'd10;
  localparam logic [3:0] ST_DONE  = 4'd11;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d  = state_q;
    cmd_o    = '0;
    finish_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (sts_i.mode)
          MODE_ALLOC: state_d = sts_i.req_ok ? ST_A_RD : ST_DONE;
          MODE_FREE:  state_d = ST_F_RD;
          MODE_RESET: begin
            cmd_o.init = 1'b1;
            cmd_o.ok   = 1'b1;
            state_d    = ST_DONE;
          end
          MODE_NONE:  state_d = ST_DONE;
        endcase
      end
      ST_A_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_A_EX;
      end
      ST_A_EX: begin
        if (!sts_i.blk_ok) begin
          state_d = ST_DONE;
        end else if (sts_i.fits) begin
          cmd_o.take = 1'b1;
          cmd_o.ok   = 1'b1;
          state_d    = sts_i.split ? ST_A_SPL : ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_A_RD;
        end
      end
      ST_A_SPL: begin
        cmd_o.split_wr = 1'b1;
        state_d        = ST_DONE;
      end
      ST_F_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_F_EX;
      end
      ST_F_EX: begin
        if (!sts_i.blk_ok) begin
          state_d = ST_M_ST;
        end else if (sts_i.hit) begin
          if (sts_i.used) begin
            cmd_o.rel = 1'b1;
            cmd_o.ok  = 1'b1;
          end
          state_d = ST_M_ST;
        end else begin
          cmd_o.step = 1'b1;
          state_d    = ST_F_RD;
        end
      end
      ST_M_ST: begin
        cmd_o.walk_rst = 1'b1;
        state_d        = ST_M_RD;
      end
      ST_M_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_M_EX;
      end
      ST_M_EX: begin
        if (!sts_i.blk_ok) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.merge = 1'b1;
          state_d     = ST_M_RD;
        end
      end
      ST_DONE: begin
        if (out_free_i) begin
          finish_o = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = state_q == ST_IDLE;

endmodule

// ----- rtl/ffba_chk.sv -----
// Port-level checks of the allocator, bound to the top level.
module ffba_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [ffba_pkg::DATA_W-1:0] m_axis_tdata,
  input logic                        m_axis_tuser
);
  import ffba_pkg::*;

  logic       in_xfer, out_xfer;
  logic [1:0] pend_q, pend_d;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_xfer = m_axis_tvalid && m_axis_tready;

  // Track items taken in whose results have not yet left
  always_comb begin
    pend_d = pend_q;
    if (in_xfer && !out_xfer) begin
      pend_d = pend_q + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_d = pend_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[ADDR_W-1:0] == '0)
    else $error("failed result carries a payload offset");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer |-> pend_q != 2'd0)
    else $error("result without an accepted item");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q == 2'd2 |-> !s_axis_tready)
    else $error("item accepted with two results outstanding");

endmodule

bind first_fit_block_allocator_core ffba_chk u_ffba_chk (.*);
